>>> design/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared widths, function codes and inter-module structs of the ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int COEF_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int HIST_W     = 40;
  localparam int HIST_FRAC  = 12;
  localparam int COEF_SHIFT = 11;                 // coefficients are Q11
  localparam int PROD_W     = COEF_W + HIST_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NIB_W      = 4;
  localparam int PAIR_W     = 3;
  localparam int SCALE_W    = 4;
  localparam int SLOT_W     = 4;
  localparam int POS_W      = 3;
  localparam int BYTE_W     = 8;

  localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(7);
  localparam logic [CH_W-1:0]  LEFT_CH    = '0;
  localparam logic [CH_W-1:0]  RIGHT_CH   = CH_W'(CHANNELS - 1);

  // result queue
  localparam int RES_DEPTH = 8;
  localparam int RES_AW    = 3;
  localparam int CNT_W     = RES_AW + 1;

  typedef enum logic [1:0] {
    FUNC_COEF = 2'd0,
    FUNC_HIST = 2'd1,
    FUNC_STRM = 2'd2
  } func_e;

  typedef logic signed [HIST_W-1:0] hist_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // one sample to decode
  typedef struct packed {
    logic               valid;
    logic [CH_W-1:0]    ch;
    logic [PAIR_W-1:0]  pair;
    logic [SCALE_W-1:0] scale;
    logic [NIB_W-1:0]   nib;
    logic               last;
  } op_t;

  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   ch;
    logic [SLOT_W-1:0] slot;
    coef_t             value;
  } coef_wr_t;

  typedef struct packed {
    logic                        valid;
    logic [CH_W-1:0]             ch;
    logic signed [SAMPLE_W-1:0]  one;
    logic signed [SAMPLE_W-1:0]  two;
  } hist_ld_t;

  typedef struct packed {
    logic            s1_valid;
    logic [CH_W-1:0] s1_ch;
    logic            busy;       // an op will still write history
    logic [1:0]      inflight;   // ops not yet in the result queue
  } core_stat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]     ch;
    logic                clip;
    logic                last;
  } result_t;

endpackage

>>> design/adpcm_core.sv
// ----------------------------------------------------------------------------
// adpcm_core
// Coefficient RAM, channel history and the predictor pipeline (read, multiply,
// accumulate/saturate, output conversion).
// ----------------------------------------------------------------------------
module adpcm_core import adpcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        op_i,
  input  coef_wr_t   coef_wr_i,
  input  hist_ld_t   hist_ld_i,
  output core_stat_t stat_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int ROW_W   = 2 * COEF_W;
  localparam int ROWS    = CHANNELS * (1 << PAIR_W);
  localparam int ROW_AW  = CH_W + PAIR_W;
  localparam int SH_W    = 6;
  localparam int TQ_W    = HIST_W - HIST_FRAC;
  localparam int SAT_LO  = HIST_W + COEF_SHIFT - 1;

  localparam hist_t HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam hist_t HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // coefficient RAM: one row per channel and pair, c2 in the upper half
  logic [ROW_W-1:0]    coef_mem [ROWS];
  logic [2*ROWS-1:0]   coef_vld_q;
  logic [ROW_AW-1:0]   rd_addr, wr_addr;
  logic [ROW_W-1:0]    coef_row_q;
  logic [1:0]          coef_rv_q;

  assign rd_addr = {op_i.ch, op_i.pair};
  assign wr_addr = {coef_wr_i.ch, coef_wr_i.slot[SLOT_W-1:1]};

  always_ff @(posedge clk_i) begin
    if (coef_wr_i.valid) begin
      if (coef_wr_i.slot[0]) begin
        coef_mem[wr_addr][ROW_W-1:COEF_W] <= coef_wr_i.value;
      end else begin
        coef_mem[wr_addr][COEF_W-1:0] <= coef_wr_i.value;
      end
    end
    coef_row_q <= coef_mem[rd_addr];
    coef_rv_q  <= {coef_vld_q[{rd_addr, 1'b1}], coef_vld_q[{rd_addr, 1'b0}]};
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (coef_wr_i.valid) begin
      coef_vld_q[{coef_wr_i.ch, coef_wr_i.slot}] <= 1'b1;
    end
  end

  // ---- stage 1: multiply ----
  logic                s1_valid_q, s1_last_q;
  logic [CH_W-1:0]     s1_ch_q;
  logic [SCALE_W-1:0]  s1_scale_q;
  logic [NIB_W-1:0]    s1_nib_q;

  hist_t hist_one_q [CHANNELS];
  hist_t hist_two_q [CHANNELS];

  coef_t                     c1, c2;
  logic signed [PROD_W-1:0]  p1_d, p2_d;
  logic signed [ACC_W-1:0]   dext, dterm_d;

  always_comb begin
    c1      = coef_rv_q[0] ? coef_t'(coef_row_q[COEF_W-1:0]) : '0;
    c2      = coef_rv_q[1] ? coef_t'(coef_row_q[ROW_W-1:COEF_W]) : '0;
    p1_d    = c1 * hist_one_q[s1_ch_q];
    p2_d    = c2 * hist_two_q[s1_ch_q];
    // nibble lands above the Q11 point, so the floor shift can follow the sum
    dext    = ACC_W'($signed(s1_nib_q));
    dterm_d = dext <<< (SH_W'(s1_scale_q) + SH_W'(COEF_SHIFT + HIST_FRAC));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q    <= op_i.ch;
    s1_scale_q <= op_i.scale;
    s1_nib_q   <= op_i.nib;
    s1_last_q  <= op_i.last;
  end

  // ---- stage 2: sum, floor, saturate, history write-back ----
  logic                      s2_valid_q, s2_last_q;
  logic [CH_W-1:0]           s2_ch_q;
  logic signed [PROD_W-1:0]  p1_q, p2_q;
  logic signed [ACC_W-1:0]   dterm_q, acc;
  logic                      hclip;
  hist_t                     q_d;

  always_comb begin
    acc   = ACC_W'(p1_q) + ACC_W'(p2_q) + dterm_q;
    hclip = !(&acc[ACC_W-1:SAT_LO] || ~|acc[ACC_W-1:SAT_LO]);
    if (hclip) begin
      q_d = acc[ACC_W-1] ? HIST_MIN : HIST_MAX;
    end else begin
      q_d = acc[SAT_LO:COEF_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ch_q   <= s1_ch_q;
    s2_last_q <= s1_last_q;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    dterm_q   <= dterm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hist_one_q[i] <= '0;
        hist_two_q[i] <= '0;
      end
    end else if (hist_ld_i.valid) begin
      hist_one_q[hist_ld_i.ch] <= hist_t'(hist_ld_i.one) <<< HIST_FRAC;
      hist_two_q[hist_ld_i.ch] <= hist_t'(hist_ld_i.two) <<< HIST_FRAC;
    end else if (s2_valid_q) begin
      hist_two_q[s2_ch_q] <= hist_one_q[s2_ch_q];
      hist_one_q[s2_ch_q] <= q_d;
    end
  end

  // ---- stage 3: truncate toward zero, clamp to 16 bits ----
  logic                      s3_valid_q, s3_last_q, s3_hclip_q;
  logic [CH_W-1:0]           s3_ch_q;
  hist_t                     s3_q;
  logic signed [TQ_W-1:0]    tq, tr;
  logic                      fix, sclip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ch_q    <= s2_ch_q;
    s3_last_q  <= s2_last_q;
    s3_hclip_q <= hclip;
    s3_q       <= q_d;
  end

  always_comb begin
    tq    = s3_q[HIST_W-1:HIST_FRAC];
    fix   = s3_q[HIST_W-1] && (|s3_q[HIST_FRAC-1:0]);
    tr    = tq + TQ_W'(fix);
    sclip = !(&tr[TQ_W-1:SAMPLE_W-1] || ~|tr[TQ_W-1:SAMPLE_W-1]);
    if (sclip) begin
      res_o.sample = tr[TQ_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      res_o.sample = tr[SAMPLE_W-1:0];
    end
    res_o.ch   = s3_ch_q;
    res_o.clip = s3_hclip_q | sclip;
    res_o.last = s3_last_q;
  end

  assign res_valid_o     = s3_valid_q;
  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s1_ch    = s1_ch_q;
  assign stat_o.busy     = s1_valid_q | s2_valid_q;
  assign stat_o.inflight = 2'(s1_valid_q) + 2'(s2_valid_q) + 2'(s3_valid_q);

  // history load must not race an op that still writes back
  a_hist_ld_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_ld_i.valid |-> !(s1_valid_q || s2_valid_q))
    else $error("history load while predictor busy");

  // same-channel op must wait for the previous write-back
  a_no_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.valid && s1_valid_q |-> op_i.ch != s1_ch_q)
    else $error("same-channel op issued behind unfinished op");

endmodule

>>> design/adpcm_res_fifo.sv
// ----------------------------------------------------------------------------
// adpcm_res_fifo
// Small result queue between the predictor and the output stream.
// ----------------------------------------------------------------------------
module adpcm_res_fifo import adpcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  result_t          push_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_data_o,
  output logic [CNT_W-1:0] count_o
);

  result_t           q_mem [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = q_mem[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign count_o     = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + RES_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RES_AW'(1);
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop);
    end
  end

  // issue credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CNT_W'(RES_DEPTH)))
    else $error("result queue overflow");

endmodule

>>> design/dsp_adpcm_audio_decoder.sv
// ----------------------------------------------------------------------------
// dsp_adpcm_audio_decoder: 4-bit DSP ADPCM decoder, mono or stereo
// Throughput: stereo byte items issue 1 sample/cycle while the result queue has credit;
// mono samples are held by the history loop; loads and headers finish without waiting,
// and a history load waits for the predictor to drain.
// ----------------------------------------------------------------------------
// Reset (async, active low) zeroes coefficients (via valid bits), history, pair/scale,
// frame position and stereo mode; no clearing pass, ready the cycle after reset.
//
// Structure:
//   item register  - holds one accepted request; tready frees it on its last step
//   sequencer      - expands a stream byte item into 2 (mono) or 4 (stereo) ops
//   adpcm_core     - coefficient RAM read, multiply, sum/saturate with history
//                    write-back, output conversion (3 stages after the RAM read)
//   adpcm_res_fifo - result queue; ops issue only against free queue credit
//
// The history loop spans the multiply stage and the accumulate stage. An op is
// held while the op in the multiply stage belongs to the same channel, so
// L/R interleave runs one op a cycle while queue credit allows, and each mono op waits for the one before it.
// ----------------------------------------------------------------------------
module dsp_adpcm_audio_decoder import adpcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] channel, [4:1] slot, [20:5] value, [36:21] value_two,
  // [44:37] left_byte, [52:45] right_byte, [55:53] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  // decoded samples
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] sample
  output logic [15:0] m_axis_tdata,
  // [0] sample_channel, [1] clipped
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,          // last_of_item
  // configuration: stereo_mode
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  typedef struct packed {
    logic [1:0]                 func;
    logic [CH_W-1:0]            ch;
    logic [SLOT_W-1:0]          slot;
    logic signed [SAMPLE_W-1:0] value;
    logic signed [SAMPLE_W-1:0] value_two;
    logic [BYTE_W-1:0]          lb;
    logic [BYTE_W-1:0]          rb;
  } item_t;

  logic                stereo_q;
  logic                item_v_q;
  item_t               item_q, item_in;
  logic [1:0]          step_q;
  logic [POS_W-1:0]    byte_pos_q;
  logic [PAIR_W-1:0]   pair_q  [CHANNELS];
  logic [SCALE_W-1:0]  scale_q [CHANNELS];

  core_stat_t          stat;
  op_t                 op;
  coef_wr_t            coef_wr;
  hist_ld_t            hist_ld;
  result_t             res, out_res;
  logic                res_valid;
  logic [CNT_W-1:0]    fifo_cnt;

  logic                stereo_eff, ch_ok, space_ok, hazard;
  logic                item_done, hdr_done, data_done, hist_done;
  logic                op_go;
  logic [1:0]          op_idx;
  logic [BYTE_W-1:0]   op_byte;

  // ---- input unpack ----
  always_comb begin
    item_in.func      = s_axis_tuser;
    item_in.ch        = s_axis_tdata[0];
    item_in.slot      = s_axis_tdata[4:1];
    item_in.value     = s_axis_tdata[20:5];
    item_in.value_two = s_axis_tdata[36:21];
    item_in.lb        = s_axis_tdata[44:37];
    item_in.rb        = s_axis_tdata[52:45];
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !item_v_q || item_done;
  assign stereo_eff    = stereo_q && (CHANNELS > 1);
  assign ch_ok         = (int'(item_q.ch) < CHANNELS);

  // op order: stereo L hi, R hi, L lo, R lo; mono L hi, L lo
  assign op_idx  = stereo_eff ? step_q : {step_q[0], 1'b0};
  assign op_byte = op_idx[0] ? item_q.rb : item_q.lb;

  always_comb begin
    op.ch    = op_idx[0] ? RIGHT_CH : LEFT_CH;
    op.pair  = pair_q[op.ch];
    op.scale = scale_q[op.ch];
    op.nib   = op_idx[1] ? op_byte[NIB_W-1:0] : op_byte[BYTE_W-1:NIB_W];
    op.last  = stereo_eff ? (step_q == 2'd3) : step_q[0];
    op.valid = op_go;
  end

  // wait for the history write-back of the same channel, and for queue room
  assign hazard   = stat.s1_valid && (stat.s1_ch == op.ch);
  assign space_ok = (5'(fifo_cnt) + 5'(stat.inflight) + 5'd1) <= 5'(RES_DEPTH);

  // ---- sequencer ----
  always_comb begin
    item_done      = 1'b0;
    hdr_done       = 1'b0;
    data_done      = 1'b0;
    hist_done      = 1'b0;
    op_go          = 1'b0;
    coef_wr.valid  = 1'b0;
    coef_wr.ch     = item_q.ch;
    coef_wr.slot   = item_q.slot;
    coef_wr.value  = item_q.value;
    hist_ld.valid  = 1'b0;
    hist_ld.ch     = item_q.ch;
    hist_ld.one    = item_q.value;
    hist_ld.two    = item_q.value_two;
    if (item_v_q) begin
      case (item_q.func)
        FUNC_COEF: begin
          item_done     = 1'b1;
          coef_wr.valid = ch_ok;
        end
        FUNC_HIST: begin
          item_done     = !stat.busy;
          hist_done     = !stat.busy && ch_ok;
          hist_ld.valid = hist_done;
        end
        FUNC_STRM: begin
          if (byte_pos_q == '0) begin
            item_done = 1'b1;
            hdr_done  = 1'b1;
          end else begin
            op_go     = !hazard && space_ok;
            item_done = op_go && op.last;
            data_done = item_done;
          end
        end
        default: begin
          item_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q   <= 1'b0;
      item_v_q   <= 1'b0;
      step_q     <= '0;
      byte_pos_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pair_q[i]  <= '0;
        scale_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        stereo_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_v_q <= 1'b1;
        step_q   <= '0;
      end else begin
        if (item_done) begin
          item_v_q <= 1'b0;
        end
        if (op.valid) begin
          step_q <= step_q + 2'd1;
        end
      end
      if (hist_done) begin
        byte_pos_q <= '0;
      end else if (hdr_done) begin
        byte_pos_q          <= POS_W'(1);
        pair_q[LEFT_CH]     <= item_q.lb[PAIR_W+SCALE_W-1:SCALE_W];
        scale_q[LEFT_CH]    <= item_q.lb[SCALE_W-1:0];
        if (stereo_eff) begin
          pair_q[RIGHT_CH]  <= item_q.rb[PAIR_W+SCALE_W-1:SCALE_W];
          scale_q[RIGHT_CH] <= item_q.rb[SCALE_W-1:0];
        end
      end else if (data_done) begin
        byte_pos_q <= (byte_pos_q >= FRAME_LAST) ? '0 : byte_pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_in;
    end
  end

  // ---- datapath ----
  adpcm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .coef_wr_i   (coef_wr),
    .hist_ld_i   (hist_ld),
    .stat_o      (stat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  adpcm_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = out_res.sample;
  assign m_axis_tuser = {out_res.clip, out_res.ch};
  assign m_axis_tlast = out_res.last;

  // a stream byte item stays until its final sample has issued
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.valid && !op.last |=> item_v_q)
    else $error("stream item released before its last sample");

endmodule
